// ===== src/sfvp_pkg.sv =====
// Package for the spirometer flow, volume and peak block.
// Field widths, session constants, register indexes and the controller state type.
// No dependencies.
package sfvp_pkg;

   localparam int PRESS_W = 20;
   localparam int FLOW_W = 21;
   localparam int MAG_W = 20;
   localparam int RAD_W = MAG_W + 8;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SPAN_W = 16;
   localparam int PROD_W = ROOT_W + SPAN_W;
   localparam int FLOW_SHIFT = 10;
   localparam int ACC_W = 40;
   localparam int PEAK_W = 20;
   localparam int IDX_W = 16;
   localparam int FEV1_W = 24;

   localparam int SAMPLE_RATE = 50;
   localparam logic [IDX_W-1:0] FEV1_INDEX = IDX_W'(50);

   // mL = acc * VOL_NUM / VOL_DEN
   localparam int VOL_NUM = 1000;
   localparam int VOL_DEN = 32 * 60 * SAMPLE_RATE;
   localparam int NUM_W = ACC_W + $clog2(VOL_NUM + 1);
   localparam int DEN_W = $clog2(VOL_DEN + 1);

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_GAIN = CSR_IDX_W'(1);
   localparam logic [PRESS_W-1:0] ZERO_OFFSET_RESET = PRESS_W'(0);
   localparam logic [SPAN_W-1:0] SPAN_GAIN_RESET = SPAN_W'(2176);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_MUL,
      ST_UPDATE,
      ST_FINISH,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ===== src/sfvp_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on sfvp_pkg.
module sfvp_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sfvp_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [sfvp_pkg::ROOT_W-1:0] root
);
   import sfvp_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial = REM_W'({root_ff, 2'b01});
      ge = rem_sh >= trial;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== src/sfvp_mul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle: root times span.
// Depends on sfvp_pkg.
module sfvp_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sfvp_pkg::ROOT_W-1:0] root,
   input  logic [sfvp_pkg::SPAN_W-1:0] span,
   output logic                       done,
   output logic [sfvp_pkg::PROD_W-1:0] product
);
   import sfvp_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SPAN_W:0]   sum;

   always_comb begin
      sum = {1'b0, prod_ff[PROD_W-1:ROOT_W]}
            + (prod_ff[0] ? {1'b0, span_ff} : '0);
      prod_in = prod_ff;
      span_in = span_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = {{SPAN_W{1'b0}}, root};
         span_in = span;
         cnt_in = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[ROOT_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      span_ff <= span_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = prod_ff;

endmodule

// ===== src/sfvp_div.sv =====
// Restoring bit-serial divider by the volume constant, with 24-bit saturation.
// Depends on sfvp_pkg.
module sfvp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sfvp_pkg::NUM_W-1:0]  numerator,
   output logic                       done,
   output logic [sfvp_pkg::FEV1_W-1:0] quotient
);
   import sfvp_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [DEN_W:0] DEN = (DEN_W + 1)'(VOL_DEN);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge = rem_sh >= DEN;
      rem_sub = rem_sh - DEN;
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numerator;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift in behind the numerator
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = (|num_ff[NUM_W-1:FEV1_W]) ? '1 : num_ff[FEV1_W-1:0];

endmodule

// ===== src/spirometer_flow_volume_peak.sv =====
// Top level of the spirometer flow, volume and peak block.
// Depends on sfvp_pkg, sfvp_sqrt, sfvp_mul and sfvp_div.
//
// req channel: one pressure beat per sample, last_sample closes a session.
// rsp channel: one beat per sample with the flow; on the closing sample it
// also carries summary_valid, FEV1 in mL and the peak flow, else those are 0.
// csr port: index 0 zero offset, index 1 span gain; other indexes are ignored.
// Write only while no sample is in flight.
//
// Sequence: a taken sample passes through ST_SQRT, ST_MUL and ST_UPDATE to
// ST_OUT, which loads its rsp beat; the next req beat is taken only once the
// controller is back in ST_IDLE. The sqrt (2 radicand bits per step) and the
// serial multiplier (one root bit per step) set the pace. A closing sample
// adds ST_FINISH and the serial divider for the mL conversion.
// The rsp beat sits in an output register: a stalled receiver does not block
// the next req beat, but a further result waits until that register frees.
// Reset (synchronous) clears session state, restores both csr registers to
// their defaults and drops rsp_valid.
module spirometer_flow_volume_peak (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [sfvp_pkg::PRESS_W-1:0] req_pressure,
   input  logic                            req_last_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [sfvp_pkg::FLOW_W-1:0] rsp_flow,
   output logic                            rsp_summary_valid,
   output logic [sfvp_pkg::FEV1_W-1:0]      rsp_fev1_volume,
   output logic [sfvp_pkg::PEAK_W-1:0]      rsp_peak_flow,
   input  logic                            csr_write_enable,
   input  logic [sfvp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfvp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfvp_pkg::*;

   state_type state_ff, state_in;

   logic [PRESS_W-1:0] zero_ff;
   logic [SPAN_W-1:0]  span_ff;

   logic               neg_ff, neg_in;
   logic               last_ff, last_in;
   logic [FLOW_W-1:0]  flow_ff, flow_in;
   logic [FLOW_W-1:0]  prev_ff, prev_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [PEAK_W-1:0]  peak_ff, peak_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ACC_W-1:0]   latch_ff, latch_in;
   logic               taken_ff, taken_in;
   logic [PEAK_W-1:0]  peak_res_ff, peak_res_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FLOW_W-1:0]  rsp_flow_ff, rsp_flow_in;
   logic               rsp_sum_ff, rsp_sum_in;
   logic [FEV1_W-1:0]  rsp_fev1_ff, rsp_fev1_in;
   logic [PEAK_W-1:0]  rsp_peak_ff, rsp_peak_in;

   logic               accept;
   logic [FLOW_W-1:0]  c;
   logic [FLOW_W-1:0]  c_abs;
   logic [RAD_W-1:0]   radicand;
   logic               sqrt_done;
   logic [ROOT_W-1:0]  root;
   logic               mul_start;
   logic               mul_done;
   logic [PROD_W-1:0]  product;
   logic               div_start;
   logic               div_done;
   logic [FEV1_W-1:0]  quotient;
   logic [NUM_W-1:0]   numerator;
   logic [FLOW_W-1:0]  m_ext;
   logic [FLOW_W-1:0]  flow_val;
   logic [FLOW_W:0]    pair_sum;
   logic               pair_pos;
   logic [ACC_W:0]     acc_sum;
   logic [ACC_W-1:0]   acc_sat;
   logic               flow_pos;
   logic               started;
   logic               rsp_free;

   assign accept = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;

   assign c = {req_pressure[PRESS_W-1], req_pressure} - {zero_ff[PRESS_W-1], zero_ff};
   assign c_abs = c[FLOW_W-1] ? -c : c;
   assign radicand = {c_abs[MAG_W-1:0], 8'b0};

   sfvp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   sfvp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .root    (root),
      .span    (span_ff),
      .done    (mul_done),
      .product (product)
   );

   sfvp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (numerator),
      .done      (div_done),
      .quotient  (quotient)
   );

   // |m| < 2^20, so the signed flow never leaves the 21-bit range
   assign m_ext = {1'b0, product[PROD_W-1:FLOW_SHIFT]};
   assign flow_val = neg_ff ? -m_ext : m_ext;
   assign pair_sum = {prev_ff[FLOW_W-1], prev_ff} + {flow_val[FLOW_W-1], flow_val};
   assign pair_pos = !pair_sum[FLOW_W] && (pair_sum != '0);
   assign acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(pair_sum[FLOW_W-1:0]);
   assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
   assign flow_pos = !flow_val[FLOW_W-1] && (flow_val != '0);
   assign started = idx_ff != '0;
   assign numerator = NUM_W'(taken_ff ? latch_ff : acc_ff) * NUM_W'(VOL_NUM);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      neg_in = neg_ff;
      last_in = last_ff;
      flow_in = flow_ff;
      prev_in = prev_ff;
      acc_in = acc_ff;
      peak_in = peak_ff;
      idx_in = idx_ff;
      latch_in = latch_ff;
      taken_in = taken_ff;
      peak_res_in = peak_res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_flow_in = rsp_flow_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_fev1_in = rsp_fev1_ff;
      rsp_peak_in = rsp_peak_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = c[FLOW_W-1];
               last_in = req_last_sample;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               mul_start = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            flow_in = flow_val;
            prev_in = flow_val;
            if (started) begin
               if (pair_pos) begin
                  acc_in = acc_sat;
               end
               if (flow_pos && (flow_val[PEAK_W-1:0] > peak_ff)) begin
                  peak_in = flow_val[PEAK_W-1:0];
               end
               if (!taken_ff && (idx_ff == FEV1_INDEX)) begin
                  latch_in = pair_pos ? acc_sat : acc_ff;
                  taken_in = 1'b1;
               end
            end
            if (idx_ff != '1) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            state_in = last_ff ? ST_FINISH : ST_OUT;
         end
         ST_FINISH: begin
            div_start = 1'b1;
            peak_res_in = peak_ff;
            prev_in = '0;
            acc_in = '0;
            peak_in = '0;
            idx_in = '0;
            latch_in = '0;
            taken_in = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_flow_in = flow_ff;
               rsp_sum_in = last_ff;
               rsp_fev1_in = last_ff ? quotient : '0;
               rsp_peak_in = last_ff ? peak_res_ff : '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= ZERO_OFFSET_RESET;
         span_ff <= SPAN_GAIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ZERO_OFFSET: zero_ff <= csr_wdata[PRESS_W-1:0];
            CSR_SPAN_GAIN:   span_ff <= csr_wdata[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      last_ff <= last_in;
      flow_ff <= flow_in;
      peak_res_ff <= peak_res_in;
      rsp_flow_ff <= rsp_flow_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_fev1_ff <= rsp_fev1_in;
      rsp_peak_ff <= rsp_peak_in;
      if (reset) begin
         prev_ff <= '0;
         acc_ff <= '0;
         peak_ff <= '0;
         idx_ff <= '0;
         latch_ff <= '0;
         taken_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         acc_ff <= acc_in;
         peak_ff <= peak_in;
         idx_ff <= idx_in;
         latch_ff <= latch_in;
         taken_ff <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flow = rsp_flow_ff;
   assign rsp_summary_valid = rsp_sum_ff;
   assign rsp_fev1_volume = rsp_fev1_ff;
   assign rsp_peak_flow = rsp_peak_ff;

endmodule

// ===== src/sfvp_checker.sv =====
// Port-level checks for spirometer_flow_volume_peak, bound to the top level.
// Depends on sfvp_pkg.
module sfvp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sfvp_pkg::FLOW_W-1:0]      rsp_flow,
   input logic                            rsp_summary_valid,
   input logic [sfvp_pkg::FEV1_W-1:0]      rsp_fev1_volume,
   input logic [sfvp_pkg::PEAK_W-1:0]      rsp_peak_flow
);
   import sfvp_pkg::*;

   // one sample in flight: a taken req beat closes the input side
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req taken while previous sample in flight");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_summary_valid) |-> (rsp_fev1_volume == '0 && rsp_peak_flow == '0))
      else $error("summary fields set on a non-closing beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_flow)
                                    && $stable(rsp_fev1_volume)))
      else $error("stalled rsp beat changed");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

bind spirometer_flow_volume_peak sfvp_checker u_sfvp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_flow          (rsp_flow),
   .rsp_summary_valid (rsp_summary_valid),
   .rsp_fev1_volume   (rsp_fev1_volume),
   .rsp_peak_flow     (rsp_peak_flow)
);

// ===== bench/spirometer_flow_volume_peak_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for spirometer_flow_volume_peak: a directed table of beats and csr writes,
// then random breathing sessions, rsp beats checked against a table row or flow/volume model.
// Depends on sfvp_pkg and the spirometer_flow_volume_peak RTL.
module spirometer_flow_volume_peak_tb;
   import sfvp_pkg::*;

   localparam int ITEM_TARGET = 1100;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 450;
   localparam int DRAIN_CYCLES = 120;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);
   localparam logic signed [PRESS_W-1:0] P_MAX = 20'sh7FFFF;
   localparam logic signed [PRESS_W-1:0] P_MIN = 20'sh80000;
   localparam longint FLOW_HI = 1048575;
   localparam longint FLOW_LO = -1048576;
   localparam longint unsigned ACC_FULL = 64'hFF_FFFF_FFFF;
   localparam longint unsigned FEV1_FULL = 64'hFF_FFFF;

   typedef struct packed {
      logic signed [FLOW_W-1:0] flow;
      logic                     summary_valid;
      logic [FEV1_W-1:0]        fev1_volume;
      logic [PEAK_W-1:0]        peak_flow;
   } flow_reading_type;

   typedef enum logic {ROW_BEAT, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      reg_index;
      logic [CSR_DATA_W-1:0]     reg_data;
      logic signed [PRESS_W-1:0] pressure;
      logic                      is_last;
      logic                      typed;
      flow_reading_type          want;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [25] = '{
      '{ROW_BEAT, '0, '0, 20'sd0, 1'b1, 1'b1, '{21'sd0, 1'b1, 24'd0, 20'd0}},
      '{ROW_BEAT, '0, '0, 20'sd1, 1'b0, 1'b1, '{21'sd34, 1'b0, 24'd0, 20'd0}},
      '{ROW_BEAT, '0, '0, -20'sd1, 1'b1, 1'b1, '{-21'sd34, 1'b1, 24'd0, 20'd0}},
      '{ROW_BEAT, '0, '0, P_MAX, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MIN, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MAX, 1'b1, 1'b0, '0},
      '{ROW_REG, CSR_SPAN_GAIN, 20'h00000, '0, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MAX, 1'b0, 1'b1, '{21'sd0, 1'b0, 24'd0, 20'd0}},
      '{ROW_BEAT, '0, '0, P_MIN, 1'b1, 1'b1, '{21'sd0, 1'b1, 24'd0, 20'd0}},
      '{ROW_REG, CSR_SPAN_GAIN, 20'hFFFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_REG, CSR_ZERO_OFFSET, 20'h80000, '0, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MAX, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MIN, 1'b1, 1'b0, '0},
      '{ROW_REG, CSR_ZERO_OFFSET, 20'h7FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MIN, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, P_MAX, 1'b1, 1'b1, '{21'sd0, 1'b1, 24'd0, 20'd0}},
      '{ROW_REG, CSR_ZERO_OFFSET, 20'h00000, '0, 1'b0, 1'b0, '0},
      '{ROW_REG, CSR_SPAN_GAIN, 20'd2176, '0, 1'b0, 1'b0, '0},
      '{ROW_REG, CSR_SPARE_LO, 20'hF0100, '0, 1'b0, 1'b0, '0},
      '{ROW_REG, CSR_SPARE_HI, 20'h0FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, 20'sd4096, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, 20'sd16384, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, 20'sd1024, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, -20'sd200, 1'b0, 1'b0, '0},
      '{ROW_BEAT, '0, '0, 20'sd0, 1'b1, 1'b0, '0}
   };

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [PRESS_W-1:0]     req_pressure = '0;
   logic                          req_last_sample = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b1;
   logic signed [FLOW_W-1:0]      rsp_flow;
   logic                          rsp_summary_valid;
   logic [FEV1_W-1:0]             rsp_fev1_volume;
   logic [PEAK_W-1:0]             rsp_peak_flow;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   // model of the block: csr copies and session state
   int                cfg_offset = 0;
   int                cfg_span = 2176;
   int                sess_prev_flow = 0;
   longint unsigned   sess_volume = 0;
   longint            sess_peak = 0;
   int                sess_index = 0;
   longint unsigned   fev1_value = 0;
   bit                fev1_held = 1'b0;

   flow_reading_type  pending_readings [$];
   int                beats_sent = 0;
   int                readings_seen = 0;
   int                mismatches = 0;
   int                cycle_count = 0;

   spirometer_flow_volume_peak i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pressure      (req_pressure),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_flow          (rsp_flow),
      .rsp_summary_valid (rsp_summary_valid),
      .rsp_fev1_volume   (rsp_fev1_volume),
      .rsp_peak_flow     (rsp_peak_flow),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned int_sqrt(input int unsigned x);
      int unsigned root = 0;
      int unsigned probe = 32'h4000_0000;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic flow_reading_type predict_reading(input logic signed [PRESS_W-1:0] p,
                                                        input logic is_last);
      flow_reading_type r;
      int              c;
      int unsigned     mag;
      longint          m;
      longint          f;
      int              s;
      longint unsigned sum;
      longint unsigned acc;
      longint unsigned ml;
      c = int'(p) - cfg_offset;
      mag = (c < 0) ? -c : c;
      m = (longint'(int_sqrt(mag << 8)) * longint'(cfg_span)) >> FLOW_SHIFT;
      f = (c < 0) ? -m : m;
      if (f > FLOW_HI) f = FLOW_HI;
      if (f < FLOW_LO) f = FLOW_LO;
      r = '0;
      r.flow = f[FLOW_W-1:0];
      r.summary_valid = is_last;
      // first beat of a session only seeds the trapezoid
      if (sess_index >= 1) begin
         s = sess_prev_flow + int'(f);
         if (s > 0) begin
            sum = sess_volume + longint'(s);
            sess_volume = (sum > ACC_FULL) ? ACC_FULL : sum;
         end
         if (f > 0 && f > sess_peak) sess_peak = f;
         if (!fev1_held && sess_index == int'(FEV1_INDEX)) begin
            fev1_value = sess_volume;
            fev1_held = 1'b1;
         end
      end
      sess_prev_flow = int'(f);
      if (sess_index < 65535) sess_index++;
      if (is_last) begin
         acc = fev1_held ? fev1_value : sess_volume;
         ml = (acc * 1000) / (32 * 60 * SAMPLE_RATE);
         r.fev1_volume = (ml > FEV1_FULL) ? FEV1_FULL[FEV1_W-1:0] : ml[FEV1_W-1:0];
         r.peak_flow = sess_peak[PEAK_W-1:0];
         sess_prev_flow = 0;
         sess_volume = 0;
         sess_peak = 0;
         sess_index = 0;
         fev1_value = 0;
         fev1_held = 1'b0;
      end
      return r;
   endfunction

   // mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 24);
      return $urandom_range(30, 90);
   endfunction

   task automatic offer_beat(input logic signed [PRESS_W-1:0] p, input logic is_last,
                             input logic typed, input flow_reading_type want);
      flow_reading_type r;
      @(negedge clock);
      req_valid <= 1'b1;
      req_pressure <= p;
      req_last_sample <= is_last;
      do @(posedge clock); while (req_stall);
      r = predict_reading(p, is_last);
      pending_readings.push_back(typed ? want : r);
      beats_sent++;
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // csr writes only once every beat in flight has come back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_readings.size() == 0);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_ZERO_OFFSET: cfg_offset = int'($signed(data));
         CSR_SPAN_GAIN:   cfg_span = int'(data[SPAN_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic retune();
      logic [31:0] raw;
      int          v;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: write_reg(CSR_ZERO_OFFSET, 20'h80000);
         1: write_reg(CSR_ZERO_OFFSET, 20'h7FFFF);
         2: write_reg(CSR_ZERO_OFFSET, raw[CSR_DATA_W-1:0]);
         default: begin
            v = int'($urandom_range(0, 8000)) - 4000;
            write_reg(CSR_ZERO_OFFSET, v[CSR_DATA_W-1:0]);
         end
      endcase
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: write_reg(CSR_SPAN_GAIN, 20'h00000);
         1: write_reg(CSR_SPAN_GAIN, {raw[19:16], 16'hFFFF});
         2: write_reg(CSR_SPAN_GAIN, {raw[19:16], 16'd2176});
         default: write_reg(CSR_SPAN_GAIN, raw[CSR_DATA_W-1:0]);
      endcase
      raw = $urandom;
      if (raw[31:30] == 2'b00) write_reg(raw[29] ? CSR_SPARE_HI : CSR_SPARE_LO, raw[19:0]);
   endtask

   initial begin : stimulus
      int          sessions;
      int          kind;
      int          len;
      int          amp;
      int          rise;
      int          shape;
      int          v;
      bit          burst;
      logic [31:0] raw;
      logic signed [PRESS_W-1:0] p;
      sessions = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[k]) begin
         if (DIRECTED_PLAN[k].kind == ROW_REG) begin
            write_reg(DIRECTED_PLAN[k].reg_index, DIRECTED_PLAN[k].reg_data);
         end else begin
            offer_beat(DIRECTED_PLAN[k].pressure, DIRECTED_PLAN[k].is_last,
                       DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].want);
            pause_sender(pick_gap());
         end
      end

      while (beats_sent < ITEM_TARGET) begin
         if (sessions % 3 == 0) retune();
         sessions++;
         burst = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            len = $urandom_range(1, 20);
         end else if (kind == 1) begin
            len = 1;
         end else begin
            v = $urandom_range(0, 9);
            len = (v < 4) ? $urandom_range(45, 55) :
                  (v < 7) ? $urandom_range(2, 44) : $urandom_range(56, 140);
         end
         amp = $urandom_range(0, 400000);
         rise = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            if (kind == 0) begin
               raw = $urandom;
               p = raw[PRESS_W-1:0];
            end else begin
               // quick rise, linear decay, the odd inhale
               if (i < rise) shape = amp * (i + 1) / rise;
               else shape = amp * (len - i) / (len - rise);
               if ($urandom_range(0, 19) == 0) shape = -shape / 4;
               v = cfg_offset + shape + int'($urandom_range(0, 2000)) - 1000;
               if (v > 524287) v = 524287;
               if (v < -524288) v = -524288;
               p = v[PRESS_W-1:0];
            end
            offer_beat(p, i == len - 1, 1'b0, '0);
            pause_sender(burst ? 0 : pick_gap());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("spirometer_flow_volume_peak_tb OK");
      end else begin
         $display("spirometer_flow_volume_peak_tb NOT OK");
      end
      $finish;
   end

   initial begin : rsp_check
      flow_reading_type got;
      flow_reading_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_flow, rsp_summary_valid, rsp_fev1_volume, rsp_peak_flow};
            readings_seen++;
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp beat, flow %0d", got.flow);
            end else begin
               want = pending_readings.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("rsp beat %0d exp/act: flow %0d/%0d summary %0b/%0b",
                              readings_seen, want.flow, got.flow,
                              want.summary_valid, got.summary_valid);
                     $display("   fev1 %0d/%0d peak %0d/%0d", want.fev1_volume,
                              got.fev1_volume, want.peak_flow, got.peak_flow);
                  end
               end
            end
         end
      end
   end

   // rsp stall pattern, with long hold-offs that back the block up into req
   initial begin : rsp_side
      int unsigned free_left;
      int unsigned stall_left;
      int          next_hold;
      free_left = 0;
      stall_left = 0;
      next_hold = 150;
      forever begin
         @(negedge clock);
         if (readings_seen >= next_hold) begin
            free_left = 0;
            stall_left = HOLD_CYCLES;
            next_hold += 550;
         end
         if (free_left == 0 && stall_left == 0) begin
            free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                      $urandom_range(1, 40);
            stall_left = pick_gap();
         end
         if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            rsp_stall <= 1'b1;
            stall_left--;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("spirometer_flow_volume_peak_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sfvp_pkg.sv
src/sfvp_sqrt.sv
src/sfvp_mul.sv
src/sfvp_div.sv
src/spirometer_flow_volume_peak.sv
src/sfvp_checker.sv
bench/spirometer_flow_volume_peak_tb.sv
